/* sv/atl_pkg.sv */
// Shared types, constants and the mnemonic table for the assembly token lexer.
package atl_pkg;

   localparam int POSITION_BITS    = 16;
   localparam int TOKEN_START_BITS = 16;
   localparam int LEN_BITS         = 16;
   localparam int VALUE_BITS       = 31;
   localparam int PREFIX_BYTES     = 5;
   localparam int MNEMONIC_COUNT   = 16;
   localparam int MAX_RESULTS      = 3;
   localparam int RES_CNT_BITS     = 2;
   localparam int FIFO_DEPTH       = 4;
   localparam int FIFO_PTR_BITS    = 2;
   localparam int FIFO_CNT_BITS    = 3;

   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
   localparam logic [35:0]         INT_TOP = 36'h0_7FFF_FFFF;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FFEED   = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SEVEN   = 8'h37;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_CASE    = 8'h20;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_V = 8'h76;
   localparam logic [7:0] CH_LOWER_X = 8'h78;

   typedef enum logic [3:0] {
      KIND_INVALID  = 4'd0,
      KIND_OPCODE   = 4'd1,
      KIND_REGISTER = 4'd2,
      KIND_IDENT    = 4'd3,
      KIND_NUMBER   = 4'd4,
      KIND_COMMA    = 4'd5,
      KIND_COLON    = 4'd6,
      KIND_NEWLINE  = 4'd7,
      KIND_EOF      = 4'd8
   } atl_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_source;
   } atl_req_type;

   typedef struct packed {
      atl_kind_type                  token_kind;
      logic [3:0]                    opcode_code;
      logic [2:0]                    register_index;
      logic [VALUE_BITS-1:0]         number_value;
      logic [TOKEN_START_BITS-1:0]   token_start;
      logic [LEN_BITS-1:0]           token_length;
      logic                          last_of_run;
   } atl_rsp_type;

   // Items one source byte produces, in order; count says how many are real.
   typedef struct packed {
      logic [RES_CNT_BITS-1:0]         count;
      atl_rsp_type [MAX_RESULTS-1:0]   item;
   } atl_push_type;

   typedef struct packed {
      logic [PREFIX_BYTES-1:0][7:0] text;
      logic [2:0]                   len;
   } atl_mnemonic_type;

   // Text is spelled last letter first so that the first letter lands in byte 0.
   function automatic atl_mnemonic_type mnemonic_entry(input logic [3:0] code);
      atl_mnemonic_type ent;
      case (code)
         4'd0:    begin ent.text = {24'd0, "zj"};  ent.len = 3'd2; end
         4'd1:    begin ent.text = {16'd0, "vom"}; ent.len = 3'd3; end
         4'd2:    begin ent.text = {16'd0, "dda"}; ent.len = 3'd3; end
         4'd3:    begin ent.text = {16'd0, "bus"}; ent.len = 3'd3; end
         4'd4:    begin ent.text = {16'd0, "lum"}; ent.len = 3'd3; end
         4'd5:    begin ent.text = {16'd0, "vid"}; ent.len = 3'd3; end
         4'd6:    begin ent.text = {16'd0, "dom"}; ent.len = 3'd3; end
         4'd7:    begin ent.text = {16'd0, "lhs"}; ent.len = 3'd3; end
         4'd8:    begin ent.text = {16'd0, "rhs"}; ent.len = 3'd3; end
         4'd9:    begin ent.text = {16'd0, "pmc"}; ent.len = 3'd3; end
         4'd10:   begin ent.text = {16'd0, "pmj"}; ent.len = 3'd3; end
         4'd11:   begin ent.text = {16'd0, "znj"}; ent.len = 3'd3; end
         4'd12:   begin ent.text = {16'd0, "ter"}; ent.len = 3'd3; end
         4'd13:   begin ent.text = {8'd0, "daol"}; ent.len = 3'd4; end
         4'd14:   begin ent.text = {8'd0, "llac"}; ent.len = 3'd4; end
         default: begin ent.text = "erots";        ent.len = 3'd5; end
      endcase
      return ent;
   endfunction

endpackage

/* sv/atl_lexer_core.sv */
// Lexer state and the per-byte token logic feeding the result queue.
module atl_lexer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  atl_pkg::atl_req_type  item,
   output atl_pkg::atl_push_type push
);
   import atl_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_COMMENT,
      MODE_WORD,
      MODE_ZERO,
      MODE_ZERO_X,
      MODE_HEX,
      MODE_OCT,
      MODE_DEC
   } atl_mode_type;

   typedef enum logic [1:0] {
      BASE_OCT,
      BASE_DEC,
      BASE_HEX
   } atl_base_type;

   atl_mode_type                 mode_ff, mode_in;
   logic [PREFIX_BYTES-1:0][7:0] prefix_ff, prefix_in;
   logic [POSITION_BITS-1:0]     tok_begin_ff, tok_begin_in;
   logic [LEN_BITS-1:0]          count_ff, count_in;
   logic [VALUE_BITS-1:0]        acc_ff, acc_in;
   logic                         ovf_ff, ovf_in;
   logic [POSITION_BITS-1:0]     pos_ff, pos_in;
   logic                         eof_sent_ff, eof_sent_in;

   logic [RES_CNT_BITS-1:0]      n;
   logic [7:0]                   c;
   logic                         do_dispatch;
   logic                         take_digit;
   atl_base_type                 digit_base;
   logic [3:0]                   digit_val;
   logic                         hex_ok;
   logic [3:0]                   hex_digit;
   logic [35:0]                  scaled;
   logic [35:0]                  sum;

   function automatic logic is_alpha(input logic [7:0] ch);
      return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= CH_ZERO && ch <= CH_NINE;
   endfunction

   function automatic logic is_blank(input logic [7:0] ch);
      return ch == CH_SPACE || ch == CH_TAB || ch == CH_VTAB || ch == CH_FFEED ||
             ch == CH_CR;
   endfunction

   function automatic atl_rsp_type make_token(
      input atl_kind_type             kind,
      input logic [VALUE_BITS-1:0]    value,
      input logic [POSITION_BITS-1:0] start,
      input logic [LEN_BITS-1:0]      len
   );
      atl_rsp_type tok;
      tok                = '0;
      tok.token_kind     = kind;
      tok.number_value   = value;
      tok.token_start    = TOKEN_START_BITS'(start);
      tok.token_length   = len;
      return tok;
   endfunction

   function automatic atl_rsp_type word_token(
      input logic [PREFIX_BYTES-1:0][7:0] text,
      input logic [LEN_BITS-1:0]          len,
      input logic [POSITION_BITS-1:0]     start
   );
      atl_rsp_type      tok;
      atl_mnemonic_type ent;
      tok = make_token(KIND_IDENT, '0, start, len);
      if (len == LEN_BITS'(3) && text[0] == CH_LOWER_R && text[1] == CH_LOWER_V &&
          text[2] >= CH_ZERO && text[2] <= CH_SEVEN) begin
         tok.token_kind     = KIND_REGISTER;
         tok.register_index = text[2][2:0];
      end
      // Bytes past the word's length are zero, so a full compare is exact.
      for (int k = 0; k < MNEMONIC_COUNT; k++) begin
         ent = mnemonic_entry(4'(k));
         if (len == LEN_BITS'(ent.len) && text == ent.text) begin
            tok.token_kind  = KIND_OPCODE;
            tok.opcode_code = 4'(k);
         end
      end
      return tok;
   endfunction

   function automatic atl_rsp_type number_token(
      input logic                     ovf,
      input logic [VALUE_BITS-1:0]    value,
      input logic [POSITION_BITS-1:0] start,
      input logic [LEN_BITS-1:0]      len
   );
      atl_rsp_type tok;
      if (ovf) begin
         tok = make_token(KIND_INVALID, '0, start, '0);
      end else begin
         tok = make_token(KIND_NUMBER, value, start, len);
      end
      return tok;
   endfunction

   always_comb begin
      c = item.char_code;
      hex_ok = 1'b1;
      hex_digit = c[3:0];
      if (is_digit(c)) begin
         hex_digit = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_digit = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      prefix_in    = prefix_ff;
      tok_begin_in = tok_begin_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      eof_sent_in  = eof_sent_ff;
      n            = '0;
      push         = '0;
      do_dispatch  = 1'b0;
      take_digit   = 1'b0;
      digit_base   = BASE_DEC;
      digit_val    = c[3:0];
      scaled       = '0;
      sum          = '0;

      if (!eof_sent_ff && item.end_of_source) begin
         // Flush whatever is pending, then close the stream.
         case (mode_ff)
            MODE_WORD: begin
               push.item[n] = word_token(prefix_ff, count_ff, tok_begin_ff);
               n = n + 1'b1;
            end
            MODE_ZERO, MODE_HEX, MODE_OCT, MODE_DEC: begin
               push.item[n] = number_token(ovf_ff, acc_ff, tok_begin_ff, count_ff);
               n = n + 1'b1;
            end
            MODE_ZERO_X: begin
               push.item[n] = make_token(KIND_NUMBER, '0, tok_begin_ff, LEN_BITS'(1));
               n = n + 1'b1;
               push.item[n] = word_token({32'd0, CH_LOWER_X}, LEN_BITS'(1),
                                         tok_begin_ff + 1'b1);
               n = n + 1'b1;
            end
            default: begin
            end
         endcase
         mode_in      = MODE_IDLE;
         push.item[n] = make_token(KIND_EOF, '0, pos_ff, '0);
         n            = n + 1'b1;
         eof_sent_in  = 1'b1;
      end else if (!eof_sent_ff) begin
         // A bare "0x": emit the zero, then let the 'x' start a word.
         if (mode_in == MODE_ZERO_X && !hex_ok) begin
            push.item[n] = make_token(KIND_NUMBER, '0, tok_begin_in, LEN_BITS'(1));
            n            = n + 1'b1;
            mode_in      = MODE_WORD;
            tok_begin_in = tok_begin_in + 1'b1;
            count_in     = LEN_BITS'(1);
            prefix_in    = {32'd0, CH_LOWER_X};
         end

         case (mode_in)
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  mode_in     = MODE_IDLE;
                  do_dispatch = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                  if (count_in < LEN_BITS'(PREFIX_BYTES)) begin
                     prefix_in[count_in[2:0]] = c | CH_CASE;
                  end
                  if (count_in != LEN_MAX) begin
                     count_in = count_in + 1'b1;
                  end
               end else begin
                  push.item[n] = word_token(prefix_in, count_in, tok_begin_in);
                  n            = n + 1'b1;
                  mode_in      = MODE_IDLE;
                  do_dispatch  = 1'b1;
               end
            end
            MODE_ZERO: begin
               if (c == CH_LOWER_X || c == (CH_LOWER_X & ~CH_CASE)) begin
                  mode_in  = MODE_ZERO_X;
                  count_in = LEN_BITS'(2);
               end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                  mode_in    = MODE_OCT;
                  take_digit = 1'b1;
                  digit_base = BASE_OCT;
               end else begin
                  push.item[n] = number_token(ovf_in, acc_in, tok_begin_in, count_in);
                  n            = n + 1'b1;
                  mode_in      = MODE_IDLE;
                  do_dispatch  = 1'b1;
               end
            end
            MODE_ZERO_X: begin
               // Only reached with a hex digit here.
               mode_in    = MODE_HEX;
               acc_in     = '0;
               take_digit = 1'b1;
               digit_base = BASE_HEX;
               digit_val  = hex_digit;
            end
            MODE_HEX: begin
               if (hex_ok) begin
                  take_digit = 1'b1;
                  digit_base = BASE_HEX;
                  digit_val  = hex_digit;
               end else begin
                  push.item[n] = number_token(ovf_in, acc_in, tok_begin_in, count_in);
                  n            = n + 1'b1;
                  mode_in      = MODE_IDLE;
                  do_dispatch  = 1'b1;
               end
            end
            MODE_OCT: begin
               if (c >= CH_ZERO && c <= CH_SEVEN) begin
                  take_digit = 1'b1;
                  digit_base = BASE_OCT;
               end else begin
                  push.item[n] = number_token(ovf_in, acc_in, tok_begin_in, count_in);
                  n            = n + 1'b1;
                  mode_in      = MODE_IDLE;
                  do_dispatch  = 1'b1;
               end
            end
            MODE_DEC: begin
               if (is_digit(c)) begin
                  take_digit = 1'b1;
                  digit_base = BASE_DEC;
               end else begin
                  push.item[n] = number_token(ovf_in, acc_in, tok_begin_in, count_in);
                  n            = n + 1'b1;
                  mode_in      = MODE_IDLE;
                  do_dispatch  = 1'b1;
               end
            end
            default: begin
               mode_in     = MODE_IDLE;
               do_dispatch = 1'b1;
            end
         endcase

         if (take_digit) begin
            if (count_in != LEN_MAX) begin
               count_in = count_in + 1'b1;
            end
            if (!ovf_in) begin
               case (digit_base)
                  BASE_OCT: scaled = {2'd0, acc_in, 3'd0};
                  BASE_HEX: scaled = {1'b0, acc_in, 4'd0};
                  default:  scaled = {2'd0, acc_in, 3'd0} + {4'd0, acc_in, 1'b0};
               endcase
               sum = scaled + {32'd0, digit_val};
               // Stop accumulating once past the signed 32-bit top.
               if (sum > INT_TOP) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = sum[VALUE_BITS-1:0];
               end
            end
         end

         if (do_dispatch && !is_blank(c)) begin
            if (c == CH_SEMI) begin
               mode_in = MODE_COMMENT;
            end else if (c == CH_COMMA) begin
               push.item[n] = make_token(KIND_COMMA, '0, pos_ff, LEN_BITS'(1));
               n            = n + 1'b1;
            end else if (c == CH_COLON) begin
               push.item[n] = make_token(KIND_COLON, '0, pos_ff, LEN_BITS'(1));
               n            = n + 1'b1;
            end else if (c == CH_NEWLINE) begin
               push.item[n] = make_token(KIND_NEWLINE, '0, pos_ff, LEN_BITS'(1));
               n            = n + 1'b1;
            end else if (is_alpha(c) || c == CH_UNDER) begin
               mode_in      = MODE_WORD;
               tok_begin_in = pos_ff;
               count_in     = LEN_BITS'(1);
               prefix_in    = {32'd0, c | CH_CASE};
            end else if (is_digit(c)) begin
               tok_begin_in = pos_ff;
               count_in     = LEN_BITS'(1);
               acc_in       = {27'd0, c[3:0]};
               ovf_in       = 1'b0;
               mode_in      = (c == CH_ZERO) ? MODE_ZERO : MODE_DEC;
            end else begin
               push.item[n] = make_token(KIND_INVALID, '0, pos_ff, '0);
               n            = n + 1'b1;
            end
         end

         pos_in = pos_ff + 1'b1;
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         push.item[i].last_of_run = (RES_CNT_BITS'(i) == n - 1'b1);
      end
      push.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         prefix_ff    <= '0;
         tok_begin_ff <= '0;
         count_ff     <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         eof_sent_ff  <= 1'b0;
      end else if (step) begin
         mode_ff      <= mode_in;
         prefix_ff    <= prefix_in;
         tok_begin_ff <= tok_begin_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         eof_sent_ff  <= eof_sent_in;
      end
   end

endmodule

/* sv/atl_result_fifo.sv */
// Small result queue: takes up to three items per cycle while room is kept, hands out one while the consumer is ready.
module atl_result_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  atl_pkg::atl_push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output atl_pkg::atl_rsp_type  rsp_data
);
   import atl_pkg::*;

   atl_rsp_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     pop;
   logic [RES_CNT_BITS-1:0]  push_cnt;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign push_cnt  = push_en ? push.count : '0;

   // Leave space for a worst-case byte, counting the slot freed this cycle.
   assign room = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - MAX_RESULTS)) ||
                 (pop && count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - MAX_RESULTS + 1));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push_cnt);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      count_in  = count_ff + FIFO_CNT_BITS'(push_cnt) - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (RES_CNT_BITS'(i) < push_cnt) begin
            mem_ff[wr_ptr_ff + FIFO_PTR_BITS'(i)] <= push.item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/assembly_token_lexer_unit.sv */
// Top level of the assembly token lexer: input register, lexer core, result queue.
//
// Takes one source byte per item and returns assembler tokens (opcodes, rv0-rv7
// registers, identifiers, numbers, comma, colon, newline, invalid, eof), each
// result flagged last_of_run on the final token a byte produced. A byte is
// accepted every cycle as long as each byte yields at most one token and the
// consumer takes a result every cycle; a byte that yields two or three tokens
// can hold the input back while the queue drains, and the input stalls whenever
// the four-entry result queue cannot take another three-token byte. A byte
// passes through the input register, then its results enter the result queue;
// it waits in the input register while the queue has no room. After the eof
// token every further item is accepted and yields nothing until reset.
module assembly_token_lexer_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  atl_pkg::atl_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output atl_pkg::atl_rsp_type rsp_data
);
   import atl_pkg::*;

   logic         in_valid_ff, in_valid_in;
   atl_req_type  in_data_ff;
   logic         room;
   logic         step;
   atl_push_type push;

   assign step      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   atl_lexer_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_data_ff),
      .push  (push)
   );

   atl_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (step),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the assembly token lexer: directed bytes, then random source text.
`timescale 1ns / 1ps

module tb_top;
   import atl_pkg::*;

   typedef enum logic [3:0] {
      LX_IDLE, LX_COMMENT, LX_WORD, LX_ZERO, LX_ZERO_X, LX_HEX, LX_OCT, LX_DEC
   } lex_mode_type;

   // One source byte, with a hand-written token where the row carries one.
   typedef struct packed {
      atl_req_type  req;
      logic         fixed;
      atl_kind_type kind;
      logic [15:0]  start;
      logic [15:0]  len;
   } source_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   atl_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   atl_rsp_type rsp_data;

   source_entry_type source_bytes[$];
   source_entry_type offer;
   atl_rsp_type      pending_tokens[$];
   int               mismatch_count = 0;
   int               send_idle_pct = 20;
   int               recv_idle_pct = 47;
   bit               hold_armed = 1'b0;
   bit               hold_off = 1'b0;

   // Lexer state as the block should hold it.
   lex_mode_type lx_mode = LX_IDLE;
   logic [39:0]  lx_prefix = '0;
   logic [15:0]  lx_begin = '0;
   int unsigned  lx_count = 0;
   logic [31:0]  lx_value = '0;
   bit           lx_overflow = 1'b0;
   logic [15:0]  lx_pos = '0;
   bit           lx_done = 1'b0;
   atl_rsp_type  run_tok [MAX_RESULTS];
   int           run_n = 0;

   assembly_token_lexer_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic string mnemonic_text(int k);
      case (k)
         0:  return "jz";
         1:  return "mov";
         2:  return "add";
         3:  return "sub";
         4:  return "mul";
         5:  return "div";
         6:  return "mod";
         7:  return "shl";
         8:  return "shr";
         9:  return "cmp";
         10: return "jmp";
         11: return "jnz";
         12: return "ret";
         13: return "load";
         14: return "call";
         default: return "store";
      endcase
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (is_digit(c)) return c - 8'h30;
      if (c >= "a" && c <= "f") return c - 8'h57;
      if (c >= "A" && c <= "F") return c - 8'h37;
      return -1;
   endfunction

   function automatic void put_token(atl_kind_type kind, logic [3:0] op, logic [2:0] rix,
                                     logic [30:0] val, logic [15:0] start, int unsigned len);
      atl_rsp_type t;
      if (run_n >= MAX_RESULTS) return;
      t.token_kind     = kind;
      t.opcode_code    = op;
      t.register_index = rix;
      t.number_value   = val;
      t.token_start    = start;
      t.token_length   = (len > LEN_MAX) ? LEN_MAX : len[15:0];
      t.last_of_run    = 1'b0;
      run_tok[run_n] = t;
      run_n++;
   endfunction

   function automatic void close_word();
      string nm;
      bit    hit;
      for (int k = 0; k < 16; k++) begin
         nm = mnemonic_text(k);
         if (nm.len() == lx_count) begin
            hit = 1'b1;
            for (int i = 0; i < nm.len(); i++)
               if (lx_prefix[8*i +: 8] != nm[i]) hit = 1'b0;
            if (hit) begin
               put_token(KIND_OPCODE, k[3:0], 3'd0, '0, lx_begin, lx_count);
               lx_mode = LX_IDLE;
               return;
            end
         end
      end
      if (lx_count == 3 && lx_prefix[7:0] == CH_LOWER_R && lx_prefix[15:8] == CH_LOWER_V &&
          lx_prefix[23:16] >= CH_ZERO && lx_prefix[23:16] <= CH_SEVEN)
         put_token(KIND_REGISTER, 4'd0, lx_prefix[18:16], '0, lx_begin, lx_count);
      else
         put_token(KIND_IDENT, 4'd0, 3'd0, '0, lx_begin, lx_count);
      lx_mode = LX_IDLE;
   endfunction

   function automatic void close_number();
      if (lx_overflow)
         put_token(KIND_INVALID, 4'd0, 3'd0, '0, lx_begin, 0);
      else
         put_token(KIND_NUMBER, 4'd0, 3'd0, lx_value[30:0], lx_begin, lx_count);
      lx_mode = LX_IDLE;
   endfunction

   function automatic void push_digit(int unsigned base, int unsigned d);
      logic [63:0] v;
      if (lx_count < LEN_MAX) lx_count++;
      if (lx_overflow) return;
      v = {32'd0, lx_value};
      v = v * base + d;
      if (v > INT_TOP) lx_overflow = 1'b1;
      else lx_value = v[31:0];
   endfunction

   function automatic void start_word(logic [7:0] c, logic [15:0] pos);
      lx_mode   = LX_WORD;
      lx_begin  = pos;
      lx_count  = 1;
      lx_prefix = {32'd0, c | CH_CASE};
   endfunction

   function automatic void route(logic [7:0] c, logic [15:0] pos);
      if (c == CH_SPACE || c == CH_TAB || c == CH_VTAB || c == CH_FFEED || c == CH_CR) return;
      if (c == CH_SEMI) begin
         lx_mode = LX_COMMENT;
      end else if (c == CH_COMMA) begin
         put_token(KIND_COMMA, 4'd0, 3'd0, '0, pos, 1);
      end else if (c == CH_COLON) begin
         put_token(KIND_COLON, 4'd0, 3'd0, '0, pos, 1);
      end else if (c == CH_NEWLINE) begin
         put_token(KIND_NEWLINE, 4'd0, 3'd0, '0, pos, 1);
      end else if (is_letter(c) || c == CH_UNDER) begin
         start_word(c, pos);
      end else if (is_digit(c)) begin
         lx_begin    = pos;
         lx_count    = 1;
         lx_value    = {24'd0, c - CH_ZERO};
         lx_overflow = 1'b0;
         lx_mode     = (c == CH_ZERO) ? LX_ZERO : LX_DEC;
      end else begin
         put_token(KIND_INVALID, 4'd0, 3'd0, '0, pos, 0);
      end
   endfunction

   function automatic void word_feed(logic [7:0] c, logic [15:0] pos);
      if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
         if (lx_count < 5) lx_prefix[8*lx_count +: 8] = c | CH_CASE;
         if (lx_count < LEN_MAX) lx_count++;
         return;
      end
      close_word();
      route(c, pos);
   endfunction

   // "0x" with no hex digit: number 0 of one byte, then the x opens a word
   function automatic void bare_prefix();
      logic [15:0] xpos;
      xpos        = lx_begin + 16'd1;
      lx_value    = '0;
      lx_overflow = 1'b0;
      lx_count    = 1;
      close_number();
      start_word(CH_LOWER_X, xpos);
   endfunction

   function automatic void lex_byte(atl_req_type req);
      logic [7:0]  c;
      logic [15:0] pos;
      int          d;
      c     = req.char_code;
      pos   = lx_pos;
      run_n = 0;
      if (lx_done) return;
      if (req.end_of_source) begin
         case (lx_mode)
            LX_WORD: close_word();
            LX_ZERO, LX_HEX, LX_OCT, LX_DEC: close_number();
            LX_ZERO_X: begin
               bare_prefix();
               close_word();
            end
            default: ;
         endcase
         lx_mode = LX_IDLE;
         put_token(KIND_EOF, 4'd0, 3'd0, '0, pos, 0);
         lx_done = 1'b1;
      end else begin
         case (lx_mode)
            LX_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  lx_mode = LX_IDLE;
                  route(c, pos);
               end
            end
            LX_WORD: word_feed(c, pos);
            LX_ZERO: begin
               if (c == "x" || c == "X") begin
                  lx_mode  = LX_ZERO_X;
                  lx_count = 2;
               end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                  lx_mode = LX_OCT;
                  push_digit(8, c - CH_ZERO);
               end else begin
                  close_number();
                  route(c, pos);
               end
            end
            LX_ZERO_X: begin
               d = hex_digit(c);
               if (d >= 0) begin
                  lx_mode  = LX_HEX;
                  lx_value = '0;
                  push_digit(16, d);
               end else begin
                  bare_prefix();
                  word_feed(c, pos);
               end
            end
            LX_HEX: begin
               d = hex_digit(c);
               if (d >= 0) begin
                  push_digit(16, d);
               end else begin
                  close_number();
                  route(c, pos);
               end
            end
            LX_OCT: begin
               if (c >= CH_ZERO && c <= CH_SEVEN) begin
                  push_digit(8, c - CH_ZERO);
               end else begin
                  close_number();
                  route(c, pos);
               end
            end
            LX_DEC: begin
               if (is_digit(c)) begin
                  push_digit(10, c - CH_ZERO);
               end else begin
                  close_number();
                  route(c, pos);
               end
            end
            default: begin
               lx_mode = LX_IDLE;
               route(c, pos);
            end
         endcase
         lx_pos = pos + 16'd1;
      end
   endfunction

   function automatic string token_text(atl_rsp_type t);
      return $sformatf("kind=%0d op=%0d reg=%0d value=%0d start=%0d len=%0d last=%0d",
                       t.token_kind, t.opcode_code, t.register_index, t.number_value,
                       t.token_start, t.token_length, t.last_of_run);
   endfunction

   function automatic source_entry_type plain_row(logic [7:0] c);
      source_entry_type e;
      e = '0;
      e.req.char_code = c;
      return e;
   endfunction

   function automatic source_entry_type fixed_row(logic [7:0] c, atl_kind_type kind,
                                                  logic [15:0] start, logic [15:0] len);
      source_entry_type e;
      e = plain_row(c);
      e.fixed = 1'b1;
      e.kind  = kind;
      e.start = start;
      e.len   = len;
      return e;
   endfunction

   // Directed source text: ",:\n", three stray bytes, " rV7,", "jZ\r", "0X,", "079;Z\n"
   function automatic source_entry_type directed_row(int i);
      case (i)
         0:  return fixed_row(CH_COMMA, KIND_COMMA, 16'd0, 16'd1);
         1:  return fixed_row(CH_COLON, KIND_COLON, 16'd1, 16'd1);
         2:  return fixed_row(CH_NEWLINE, KIND_NEWLINE, 16'd2, 16'd1);
         3:  return fixed_row(8'hFF, KIND_INVALID, 16'd3, 16'd0);
         4:  return fixed_row(8'h00, KIND_INVALID, 16'd4, 16'd0);
         5:  return fixed_row(8'h80, KIND_INVALID, 16'd5, 16'd0);
         6:  return plain_row(CH_SPACE);
         7:  return plain_row("r");
         8:  return plain_row("V");
         9:  return plain_row("7");
         10: return plain_row(CH_COMMA);
         11: return plain_row("j");
         12: return plain_row("Z");
         13: return fixed_row(CH_CR, KIND_OPCODE, 16'd11, 16'd2);
         14: return plain_row("0");
         15: return plain_row("X");
         16: return plain_row(CH_COMMA);
         17: return plain_row("0");
         18: return plain_row("7");
         19: return plain_row("9");
         20: return plain_row(CH_SEMI);
         21: return plain_row("Z");
         default: return fixed_row(CH_NEWLINE, KIND_NEWLINE, 16'd22, 16'd1);
      endcase
   endfunction

   // Letters go in random case.
   task automatic feed_char(logic [7:0] c);
      if (c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c & 8'hDF;
      source_bytes.push_back(plain_row(c));
   endtask

   task automatic feed_text(string s);
      for (int i = 0; i < s.len(); i++) feed_char(s[i]);
   endtask

   function automatic logic [7:0] word_char(bit first);
      int unsigned k;
      k = $urandom_range(first ? 52 : 62);
      if (k < 26) return 8'(8'h61 + k);
      if (k < 52) return 8'(8'h41 + k - 26);
      if (k < 62 && !first) return 8'(8'h30 + k - 52);
      return CH_UNDER;
   endfunction

   task automatic queue_random_piece();
      int unsigned pick, n;
      logic [63:0] v;
      pick = $urandom_range(99);
      if (pick < 14) begin
         feed_text(mnemonic_text($urandom_range(15)));
      end else if (pick < 22) begin
         feed_text("rv");
         feed_char(8'(8'h30 + $urandom_range(9)));
         if ($urandom_range(9) == 0) feed_char(CH_UNDER);
      end else if (pick < 32) begin
         n = ($urandom_range(9) == 0) ? 14 : $urandom_range(7);
         feed_char(word_char(1'b1));
         repeat (n) feed_char(word_char(1'b0));
      end else if (pick < 44) begin
         case ($urandom_range(4))
            0: v = 64'd2147483647;
            1: v = 64'd2147483648;
            2: v = {$urandom, $urandom};
            3: v = {32'd0, $urandom_range(999)};
            default: v = {32'd0, $urandom & 32'h7FFF_FFFF};
         endcase
         feed_text($sformatf("%0d", v));
      end else if (pick < 54) begin
         feed_text("0x");
         case ($urandom_range(5))
            0: ;
            1: feed_text("7fffffff");
            2: feed_text("80000000");
            3: feed_text($sformatf("%0h", $urandom));
            default: feed_text($sformatf("%0h", $urandom_range(4095)));
         endcase
      end else if (pick < 62) begin
         feed_char("0");
         case ($urandom_range(4))
            0: feed_text("17777777777");
            1: feed_text("20000000000");
            2: feed_text("777777777777");
            default: feed_text($sformatf("%0o", $urandom_range(4095)));
         endcase
         if ($urandom_range(3) == 0) feed_char($urandom_range(1) ? "8" : "9");
      end else if (pick < 66) begin
         feed_char("0");
      end else if (pick < 76) begin
         case ($urandom_range(2))
            0: feed_char(CH_COMMA);
            1: feed_char(CH_COLON);
            default: feed_char(CH_NEWLINE);
         endcase
      end else if (pick < 84) begin
         case ($urandom_range(4))
            0: feed_char(CH_SPACE);
            1: feed_char(CH_TAB);
            2: feed_char(CH_VTAB);
            3: feed_char(CH_FFEED);
            default: feed_char(CH_CR);
         endcase
      end else if (pick < 90) begin
         feed_char(CH_SEMI);
         repeat ($urandom_range(6)) begin
            v = {32'd0, $urandom_range(255)};
            source_bytes.push_back(plain_row(v[7:0] == CH_NEWLINE ? CH_SPACE : v[7:0]));
         end
         feed_char(CH_NEWLINE);
      end else begin
         source_bytes.push_back(plain_row(8'($urandom_range(255))));
      end
      if ($urandom_range(99) < 55) begin
         case ($urandom_range(4))
            0: feed_char(CH_COMMA);
            1: feed_char(CH_COLON);
            2: feed_char(CH_NEWLINE);
            3: feed_char(CH_TAB);
            default: feed_char(CH_SPACE);
         endcase
      end
   endtask

   task automatic queue_phase(int count);
      int target;
      target = source_bytes.size() + count;
      while (source_bytes.size() < target) queue_random_piece();
   endtask

   always @(posedge clock) begin : stream_handshake
      atl_rsp_type tok;
      atl_rsp_type want;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            lex_byte(offer.req);
            if (offer.fixed) begin
               want = '0;
               want.token_kind   = offer.kind;
               want.token_start  = offer.start;
               want.token_length = offer.len;
               want.last_of_run  = 1'b1;
               pending_tokens.push_back(want);
            end else begin
               for (int i = 0; i < run_n; i++) begin
                  tok = run_tok[i];
                  tok.last_of_run = (i == run_n - 1);
                  pending_tokens.push_back(tok);
               end
            end
         end
         if (!req_valid || req_ready) begin
            if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offer = source_bytes.pop_front();
               req_data  <= offer.req;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (pending_tokens.size() == 0) begin
               $display("%0t ns: unexpected token, expected none, got %s",
                        $time, token_text(rsp_data));
               mismatch_count++;
            end else begin
               want = pending_tokens.pop_front();
               if (rsp_data.token_kind !== want.token_kind ||
                   rsp_data.opcode_code !== want.opcode_code ||
                   rsp_data.register_index !== want.register_index ||
                   rsp_data.number_value !== want.number_value ||
                   rsp_data.token_start !== want.token_start ||
                   rsp_data.token_length !== want.token_length ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  $display("%0t ns: token mismatch, expected %s, got %s",
                           $time, token_text(want), token_text(rsp_data));
                  mismatch_count++;
               end
            end
         end

         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Long hold-off: let the result queue fill and back up into the input.
   initial begin : receiver_hold
      wait (hold_armed);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (80) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : run_sequence
      source_entry_type e;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      for (int i = 0; i < 23; i++) source_bytes.push_back(directed_row(i));
      queue_phase(120);
      while (source_bytes.size() != 0) @(negedge clock);

      send_idle_pct = 47;
      recv_idle_pct = 20;
      queue_phase(120);
      while (source_bytes.size() != 0) @(negedge clock);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_phase(120);
      hold_armed = 1'b1;

      // Leave the lexer in some pending state, then end the source.
      case ($urandom_range(6))
         0: feed_text("store");
         1: feed_text("rv3");
         2: feed_text("1234");
         3: feed_text("0x");
         4: feed_char("0");
         5: feed_text("; tail");
         default: ;
      endcase
      e = plain_row(8'($urandom_range(255)));
      e.req.end_of_source = 1'b1;
      source_bytes.push_back(e);
      // Bytes after the end of source are taken and dropped.
      repeat (3) begin
         e = plain_row(8'($urandom_range(255)));
         e.req.end_of_source = 1'($urandom_range(1));
         source_bytes.push_back(e);
      end

      while (source_bytes.size() != 0 || req_valid) @(negedge clock);
      while (pending_tokens.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* assembly_token_lexer_unit.f */
sv/atl_pkg.sv
sv/atl_lexer_core.sv
sv/atl_result_fifo.sv
sv/assembly_token_lexer_unit.sv
test/tb_top.sv
